// ----- sv/c8alu_pkg.sv -----
`default_nettype none

package c8alu_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned AddrWidth = 16;
   localparam int unsigned OpWidth   = 4;

   localparam logic [ByteWidth-1:0] BYTE_MASK = 8'hFF;

   // Operation codes carried in the operation field of an item.
   typedef enum logic [OpWidth-1:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_ANDX_SUB = 4'd2,
      OP_SHL      = 4'd3,
      OP_SHR      = 4'd4,
      OP_ROL      = 4'd5,
      OP_ROR      = 4'd6,
      OP_DEC_CMP  = 4'd7,
      OP_INC_SUB  = 4'd8,
      OP_ROL_AND  = 4'd9,
      OP_ROR_ADD  = 4'd10,
      OP_SHL_OR   = 4'd11,
      OP_SHR_EOR  = 4'd12
   } op_type;

   typedef struct packed {
      logic [OpWidth-1:0]   operation;
      logic [AddrWidth-1:0] address;
      logic [ByteWidth-1:0] operand;
      logic [ByteWidth-1:0] acc_in;
      logic [ByteWidth-1:0] x_in;
      logic                 carry_in;
      logic                 overflow_in;
   } req_type;

   typedef struct packed {
      logic [ByteWidth-1:0] acc_out;
      logic [ByteWidth-1:0] x_out;
      logic                 carry_out;
      logic                 zero_out;
      logic                 negative_out;
      logic                 overflow_out;
      logic                 write_enable;
      logic [AddrWidth-1:0] write_address;
      logic [ByteWidth-1:0] write_data;
   } rsp_type;

endpackage

`default_nettype wire

// ----- sv/c8alu_chan_if.sv -----
`default_nettype none

// Valid/ready channel carrying one item of the given payload type.
interface c8alu_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ----- sv/c8alu_core.sv -----
`default_nettype none

// Combinational datapath: one shared 8-bit adder, the shift/rotate unit
// and the logic operations, with the flags taken from the selected byte.
module c8alu_core (
   input  c8alu_pkg::req_type req,
   output c8alu_pkg::rsp_type rsp
);

   import c8alu_pkg::*;

   op_type               op;
   logic [ByteWidth-1:0] m;
   logic [ByteWidth-1:0] a;
   logic [ByteWidth-1:0] x;
   logic                 c;
   logic [ByteWidth-1:0] shl_val;
   logic [ByteWidth-1:0] shr_val;
   logic [ByteWidth-1:0] rol_val;
   logic [ByteWidth-1:0] ror_val;
   logic [ByteWidth-1:0] dec_val;
   logic [ByteWidth-1:0] inc_val;
   logic [ByteWidth-1:0] add_a;
   logic [ByteWidth-1:0] add_b;
   logic                 add_c;
   logic [ByteWidth:0]   sum_full;
   logic [ByteWidth-1:0] sum;
   logic                 sum_c;
   logic                 sum_v;
   logic [ByteWidth-1:0] flag_byte;

   assign op = op_type'(req.operation);
   assign m  = req.operand;
   assign a  = req.acc_in;
   assign x  = req.x_in;
   assign c  = req.carry_in;

   assign shl_val = {m[ByteWidth-2:0], 1'b0};
   assign shr_val = {1'b0, m[ByteWidth-1:1]};
   assign rol_val = {m[ByteWidth-2:0], c};
   assign ror_val = {c, m[ByteWidth-1:1]};
   assign dec_val = m - 8'd1;
   assign inc_val = m + 8'd1;

   // Subtraction is addition of the inverted operand with carry as not-borrow.
   always_comb begin
      add_a = a;
      add_b = m;
      add_c = c;
      case (op)
         OP_SUB: begin
            add_b = ~m;
         end
         OP_ANDX_SUB: begin
            add_a = a & x;
            add_b = ~m;
            add_c = 1'b1;
         end
         OP_DEC_CMP: begin
            add_b = ~dec_val;
            add_c = 1'b1;
         end
         OP_INC_SUB: begin
            add_b = ~inc_val;
         end
         OP_ROR_ADD: begin
            add_b = ror_val;
            add_c = m[0];
         end
         default: begin
         end
      endcase
   end

   assign sum_full = {1'b0, add_a} + {1'b0, add_b} + {{ByteWidth{1'b0}}, add_c};
   assign sum      = sum_full[ByteWidth-1:0];
   assign sum_c    = sum_full[ByteWidth];
   assign sum_v    = (add_b[ByteWidth-1] ^ sum[ByteWidth-1])
                   & (add_a[ByteWidth-1] ^ sum[ByteWidth-1]);

   always_comb begin
      rsp.acc_out       = a;
      rsp.x_out         = x;
      rsp.carry_out     = c;
      rsp.overflow_out  = req.overflow_in;
      rsp.write_enable  = 1'b0;
      rsp.write_data    = '0;
      rsp.write_address = req.address;
      flag_byte         = a;
      case (op)
         OP_ADD, OP_SUB: begin
            rsp.acc_out      = sum;
            rsp.carry_out    = sum_c;
            rsp.overflow_out = sum_v;
            flag_byte        = sum;
         end
         OP_ANDX_SUB: begin
            rsp.x_out     = sum;
            rsp.carry_out = sum_c;
            flag_byte     = sum;
         end
         OP_SHL: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = shl_val;
            rsp.carry_out    = m[ByteWidth-1];
            flag_byte        = shl_val;
         end
         OP_SHR: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = shr_val;
            rsp.carry_out    = m[0];
            flag_byte        = shr_val;
         end
         OP_ROL: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = rol_val;
            rsp.carry_out    = m[ByteWidth-1];
            flag_byte        = rol_val;
         end
         OP_ROR: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = ror_val;
            rsp.carry_out    = m[0];
            flag_byte        = ror_val;
         end
         OP_DEC_CMP: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = dec_val;
            rsp.carry_out    = sum_c;
            flag_byte        = sum;
         end
         OP_INC_SUB: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = inc_val;
            rsp.acc_out      = sum;
            rsp.carry_out    = sum_c;
            rsp.overflow_out = sum_v;
            flag_byte        = sum;
         end
         OP_ROL_AND: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = rol_val;
            rsp.acc_out      = a & rol_val;
            rsp.carry_out    = m[ByteWidth-1];
            flag_byte        = a & rol_val;
         end
         OP_ROR_ADD: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = ror_val;
            rsp.acc_out      = sum;
            rsp.carry_out    = sum_c;
            rsp.overflow_out = sum_v;
            flag_byte        = sum;
         end
         OP_SHL_OR: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = shl_val;
            rsp.acc_out      = a | shl_val;
            rsp.carry_out    = m[ByteWidth-1];
            flag_byte        = a | shl_val;
         end
         OP_SHR_EOR: begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = shr_val;
            rsp.acc_out      = a ^ shr_val;
            rsp.carry_out    = m[0];
            flag_byte        = a ^ shr_val;
         end
         default: begin
         end
      endcase
      rsp.zero_out     = (flag_byte == '0);
      rsp.negative_out = flag_byte[ByteWidth-1];
   end

endmodule

`default_nettype wire

// ----- sv/cpu8_rmw_alu_with_flags.sv -----
// 8-bit processor ALU with the read-modify-write forms, no decimal mode.
// Each item on req_if carries an operation, the operand byte, its address
// and the current A, X, carry and overflow; each item on rsp_if gives the
// new A, X and flags together with a write-back byte, its address and a
// write enable, which is set for the shift, rotate and combined
// read-modify-write operations. Write data reads as zero when the enable
// is clear, and unused operation codes leave A, X, carry and overflow
// untouched. The block takes one item per cycle while the result channel
// is not stalled: an item is held in the input register, passes through
// the single adder and shift unit of the datapath, and is captured in the
// result register. A new item is taken into an empty input register while
// an earlier result still waits to be collected. The block keeps no state
// from one item to the next and needs no clearing after reset.
`default_nettype none

module cpu8_rmw_alu_with_flags (
   input  wire         clock,
   input  wire         reset,
   c8alu_chan_if.sink   req_if,
   c8alu_chan_if.source rsp_if
);

   import c8alu_pkg::*;

   // Input register stage.
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   req_type in_data_in;

   // Result register stage.
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;

   rsp_type core_rsp;
   logic    out_free;
   logic    in_free;

   // A stage may load whenever it is empty or its content leaves this cycle.
   assign out_free = !out_valid_ff || rsp_if.ready;
   assign in_free  = !in_valid_ff || out_free;

   assign req_if.ready   = in_free;
   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

   c8alu_core u_core (
      .req (in_data_ff),
      .rsp (core_rsp)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (in_free) begin
         in_valid_in = req_if.valid;
         in_data_in  = req_if.payload;
      end
      if (out_free) begin
         out_valid_in = in_valid_ff;
         out_data_in  = core_rsp;
      end
   end

   // Only the valid flags need reset; the payload registers follow them.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

endmodule

`default_nettype wire

// ----- sv/c8alu_checker.sv -----
`default_nettype none

module c8alu_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire       rsp_write_enable,
   input wire [7:0] rsp_write_data
);

   // A result on offer stays on offer until it is taken.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // The cycle after reset no result is on offer.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

   // A result never carries write data without its write enable.
   a_wdata_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_write_data == 8'h00)
      else $error("write data set while write enable is clear");

   // With the result side free once the item sits in the input register, an accepted item reaches the result register.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("accepted item did not reach the result register");

endmodule

bind cpu8_rmw_alu_with_flags c8alu_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_write_enable (rsp_if.payload.write_enable),
   .rsp_write_data   (rsp_if.payload.write_data)
);

`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none

// Self-checking bench for the 8-bit ALU with its read-modify-write forms.
// Every accepted item has an outcome due, written out by hand or worked
// out by a predictor written from the behaviour of the block. It joins
// a queue of outcomes still due, and each result the block hands back
// is compared, field by field, with the oldest entry in that queue.
module tb;

   import c8alu_pkg::*;

   // The operation field is four bits wide, but only thirteen codes are
   // defined. The spare codes must behave as a no-operation.
   localparam logic [OpWidth-1:0] OpSpareMin = 4'd13;
   localparam logic [OpWidth-1:0] OpSpareMax = 4'd15;

   localparam int RandomItems   = 1800;
   localparam int CycleLimit    = 500000;
   localparam int SettleCycles  = 8;
   localparam int PrintedMisses = 40;

   // Ways in which the result side takes its items.
   typedef enum int {
      TAKE_FREELY,
      TAKE_SPARSELY,
      TAKE_WITH_LONG_STALLS,
      TAKE_ALTERNATE
   } take_mode_type;

   // One row of the directed table. Where typed is set, the expected
   // outcome is written out by hand. Otherwise the predictor supplies it.
   typedef struct packed {
      req_type stim;
      logic    typed;
      rsp_type want;
   } alu_case_type;

   logic clock;
   logic reset;
   int   cycle_count    = 0;
   int   mismatch_count = 0;
   int   burst_left     = 0;

   rsp_type      alu_outcomes_due[$];
   alu_case_type alu_cases[$];

   c8alu_chan_if #(.payload_type(req_type)) req_ch ();
   c8alu_chan_if #(.payload_type(rsp_type)) rsp_ch ();

   cpu8_rmw_alu_with_flags u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Free-running clock with a period of four time units.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Eight-bit addition with carry in. It also returns the carry out and
   // the signed overflow. A subtraction is the same sum taken with the
   // inverted operand, where a carry out of one means that nothing was
   // borrowed.
   function automatic logic [7:0] byte_add(input logic [7:0] a, input logic [7:0] m,
                                           input logic cin, output logic cout,
                                           output logic ovf);
      logic [8:0] sum;
      sum  = {1'b0, a} + {1'b0, m} + {8'd0, cin};
      cout = sum[8];
      ovf  = (m[7] ^ sum[7]) & (a[7] ^ sum[7]);
      return sum[7:0];
   endfunction

   // Predicts the single outcome of one item. The flag byte is whatever the
   // operation reports on: the new A for most operations, the new X for
   // andx-sub, the modified memory byte for the plain shifts and rotates,
   // and the comparison difference for dec-cmp.
   function automatic rsp_type alu_predict(input req_type r);
      rsp_type    o;
      logic [7:0] acc;
      logic [7:0] xr;
      logic [7:0] wd;
      logic [7:0] flag_byte;
      logic       c;
      logic       v;
      logic       we;
      logic       spill;
      logic       lost_v;
      acc       = r.acc_in;
      xr        = r.x_in;
      c         = r.carry_in;
      v         = r.overflow_in;
      wd        = '0;
      we        = 1'b0;
      flag_byte = acc;
      case (r.operation)
         OP_ADD: begin
            acc       = byte_add(acc, r.operand, c, c, v);
            flag_byte = acc;
         end
         OP_SUB: begin
            acc       = byte_add(acc, ~r.operand, c, c, v);
            flag_byte = acc;
         end
         OP_ANDX_SUB: begin
            // The overflow of this subtraction is discarded and V is kept.
            xr        = byte_add(acc & xr, ~r.operand, 1'b1, c, lost_v);
            flag_byte = xr;
         end
         OP_SHL: begin
            {c, wd}   = {r.operand, 1'b0};
            we        = 1'b1;
            flag_byte = wd;
         end
         OP_SHR: begin
            {wd, c}   = {1'b0, r.operand};
            we        = 1'b1;
            flag_byte = wd;
         end
         OP_ROL: begin
            {c, wd}   = {r.operand, c};
            we        = 1'b1;
            flag_byte = wd;
         end
         OP_ROR: begin
            {wd, c}   = {c, r.operand};
            we        = 1'b1;
            flag_byte = wd;
         end
         OP_DEC_CMP: begin
            wd        = r.operand - 8'd1;
            we        = 1'b1;
            flag_byte = byte_add(acc, ~wd, 1'b1, c, lost_v);
         end
         OP_INC_SUB: begin
            wd        = r.operand + 8'd1;
            we        = 1'b1;
            acc       = byte_add(acc, ~wd, c, c, v);
            flag_byte = acc;
         end
         OP_ROL_AND: begin
            {c, wd}   = {r.operand, c};
            we        = 1'b1;
            acc       = acc & wd;
            flag_byte = acc;
         end
         OP_ROR_ADD: begin
            // The bit that is rotated out becomes the carry into the sum.
            {wd, spill} = {c, r.operand};
            we          = 1'b1;
            acc         = byte_add(acc, wd, spill, c, v);
            flag_byte   = acc;
         end
         OP_SHL_OR: begin
            {c, wd}   = {r.operand, 1'b0};
            we        = 1'b1;
            acc       = acc | wd;
            flag_byte = acc;
         end
         OP_SHR_EOR: begin
            {wd, c}   = {1'b0, r.operand};
            we        = 1'b1;
            acc       = acc ^ wd;
            flag_byte = acc;
         end
         default: begin
         end
      endcase
      o.acc_out       = acc;
      o.x_out         = xr;
      o.carry_out     = c;
      o.zero_out      = (flag_byte == 8'd0);
      o.negative_out  = flag_byte[7];
      o.overflow_out  = v;
      o.write_enable  = we;
      o.write_address = r.address;
      o.write_data    = wd;
      return o;
   endfunction

   function automatic req_type mk_req(input logic [OpWidth-1:0] op, input logic [15:0] addr,
                                      input logic [7:0] m, input logic [7:0] a,
                                      input logic [7:0] x, input logic c, input logic v);
      req_type r;
      r.operation   = op;
      r.address     = addr;
      r.operand     = m;
      r.acc_in      = a;
      r.x_in        = x;
      r.carry_in    = c;
      r.overflow_in = v;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input logic [7:0] a, input logic [7:0] x, input logic c,
                                      input logic z, input logic n, input logic v,
                                      input logic we, input logic [15:0] wa,
                                      input logic [7:0] wd);
      rsp_type o;
      o.acc_out       = a;
      o.x_out         = x;
      o.carry_out     = c;
      o.zero_out      = z;
      o.negative_out  = n;
      o.overflow_out  = v;
      o.write_enable  = we;
      o.write_address = wa;
      o.write_data    = wd;
      return o;
   endfunction

   // Values at and around the sign and carry boundaries, where the flags
   // are most likely to go wrong.
   function automatic logic [7:0] edgy_byte();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0: b = 8'h00;
         1: b = 8'hFF;
         2: b = 8'h7F;
         3: b = 8'h80;
         4: b = 8'h01;
         default: b = 8'($urandom);
      endcase
      return b;
   endfunction

   // Most random items use a defined operation. A small share uses the
   // spare codes, and a quarter of the operands are drawn with a bias towards the boundaries.
   function automatic req_type random_item();
      req_type r;
      if ($urandom_range(0, 19) == 0) begin
         r.operation = 4'($urandom_range(OpSpareMin, OpSpareMax));
      end else begin
         r.operation = 4'($urandom_range(OP_ADD, OP_SHR_EOR));
      end
      r.address     = 16'($urandom);
      r.operand     = ($urandom_range(0, 3) == 0) ? edgy_byte() : 8'($urandom);
      r.acc_in      = ($urandom_range(0, 3) == 0) ? edgy_byte() : 8'($urandom);
      r.x_in        = 8'($urandom);
      r.carry_in    = 1'($urandom);
      r.overflow_in = 1'($urandom);
      return r;
   endfunction

   // One line per mismatch. Printing stops after a while, but counting
   // does not.
   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PrintedMisses) begin
         $display("cycle %0d: %s: got %0h, expected %0h", cycle_count, what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (alu_outcomes_due.size() == 0) begin
         report_mismatch("result with no item outstanding, write address",
                         int'(got.write_address), 0);
      end else begin
         want = alu_outcomes_due.pop_front();
         if (got.acc_out !== want.acc_out)
            report_mismatch("acc_out", int'(got.acc_out), int'(want.acc_out));
         if (got.x_out !== want.x_out)
            report_mismatch("x_out", int'(got.x_out), int'(want.x_out));
         if (got.carry_out !== want.carry_out)
            report_mismatch("carry_out", int'(got.carry_out), int'(want.carry_out));
         if (got.zero_out !== want.zero_out)
            report_mismatch("zero_out", int'(got.zero_out), int'(want.zero_out));
         if (got.negative_out !== want.negative_out)
            report_mismatch("negative_out", int'(got.negative_out),
                            int'(want.negative_out));
         if (got.overflow_out !== want.overflow_out)
            report_mismatch("overflow_out", int'(got.overflow_out),
                            int'(want.overflow_out));
         if (got.write_enable !== want.write_enable)
            report_mismatch("write_enable", int'(got.write_enable),
                            int'(want.write_enable));
         if (got.write_address !== want.write_address)
            report_mismatch("write_address", int'(got.write_address),
                            int'(want.write_address));
         if (got.write_data !== want.write_data)
            report_mismatch("write_data", int'(got.write_data), int'(want.write_data));
      end
   endtask

   // Lowers valid for as long as n says. While valid is low, the payload carries
   // random noise, which the block must ignore.
   task automatic hold_off(input int n);
      @(negedge clock);
      req_ch.valid   <= 1'b0;
      req_ch.payload <= random_item();
      repeat (n - 1) begin
         @(negedge clock);
         req_ch.payload <= random_item();
      end
   endtask

   // The sender works in bursts. Most bursts are short, but some are long
   // enough to keep the input full for a good while, and each burst ends
   // with a gap of random length.
   task automatic pace_sender();
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         hold_off(($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                              : $urandom_range(1, 4));
      end
      burst_left--;
   endtask

   // Presents one item and waits for it to be taken. Valid stays high after
   // the item is taken, until the next falling edge either presents the
   // next item or lowers valid.
   task automatic offer_item(input req_type it, input rsp_type want);
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.payload <= it;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      alu_outcomes_due.push_back(want);
   endtask

   // Lowers valid and waits until every outstanding result has come back.
   task automatic drain_outcomes();
      hold_off(1);
      while (alu_outcomes_due.size() != 0) @(posedge clock);
   endtask

   // Result side: ready is driven at the falling edge. As the run goes on, the
   // receiver switches from one way of taking results to another, so
   // stalls fall on every phase of the pipeline, and some stretches have
   // no stalls at all.
   initial begin : result_pacing
      take_mode_type mode;
      int            stall_left;
      mode         = TAKE_FREELY;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (cycle_count % 200 == 0) mode = take_mode_type'($urandom_range(0, 3));
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               TAKE_FREELY: rsp_ch.ready <= 1'b1;
               TAKE_SPARSELY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               TAKE_WITH_LONG_STALLS: begin
                  rsp_ch.ready <= 1'b1;
                  if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(4, 24);
               end
               default: rsp_ch.ready <= cycle_count[0];
            endcase
         end
      end
   end

   // Counts cycles, enforces the run limit and checks each result that is
   // taken. Outputs are sampled at the rising edge, before the block
   // updates them.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("** cpu8_rmw_alu_with_flags: FAILED **");
         $finish;
      end else if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         check_result(rsp_ch.payload);
      end
   end

   initial begin : stimulus
      req_type it;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;

      // The directed table. It covers the carry and overflow boundaries of
      // add and subtract, a zero result from andx-sub, the bits shifted
      // out at both ends, the rotates that feed the carry in, the
      // wrap-around of decrement and increment, the sum of rotate-add that
      // carries in the bit rotated out, and the spare codes, which must
      // leave everything as it was.
      alu_cases.push_back('{mk_req(OP_ADD, 16'h0000, 8'h01, 8'hFF, 8'h55, 1'b0, 1'b0), 1'b1,
                            mk_rsp(8'h00, 8'h55, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 8'h00)});
      alu_cases.push_back('{mk_req(OP_ADD, 16'hFFFF, 8'h00, 8'h7F, 8'h00, 1'b1, 1'b0), 1'b1,
                            mk_rsp(8'h80, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFF, 8'h00)});
      alu_cases.push_back('{mk_req(OP_ADD, 16'h2222, 8'h80, 8'h80, 8'h11, 1'b0, 1'b0), 1'b0, '0});
      alu_cases.push_back('{mk_req(OP_SUB, 16'h1234, 8'h01, 8'h00, 8'hAA, 1'b1, 1'b1), 1'b1,
                            mk_rsp(8'hFF, 8'hAA, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h1234, 8'h00)});
      alu_cases.push_back('{mk_req(OP_SUB, 16'h0001, 8'h01, 8'h80, 8'h00, 1'b1, 1'b0), 1'b1,
                            mk_rsp(8'h7F, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0001, 8'h00)});
      alu_cases.push_back('{mk_req(OP_SUB, 16'h3333, 8'hFF, 8'h7F, 8'hFF, 1'b0, 1'b0), 1'b0, '0});
      alu_cases.push_back('{mk_req(OP_ANDX_SUB, 16'h4321, 8'h0F, 8'hFF, 8'h0F, 1'b0, 1'b1), 1'b1,
                            mk_rsp(8'hFF, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 16'h4321, 8'h00)});
      alu_cases.push_back('{mk_req(OP_ANDX_SUB, 16'h4444, 8'hFF, 8'h80, 8'hF0, 1'b1, 1'b0), 1'b0,
                            '0});
      alu_cases.push_back('{mk_req(OP_SHL, 16'hBEEF, 8'h80, 8'h12, 8'h34, 1'b0, 1'b0), 1'b1,
                            mk_rsp(8'h12, 8'h34, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 16'hBEEF, 8'h00)});
      alu_cases.push_back('{mk_req(OP_SHR, 16'h8000, 8'h01, 8'hFF, 8'hFF, 1'b1, 1'b1), 1'b1,
                            mk_rsp(8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h8000, 8'h00)});
      alu_cases.push_back('{mk_req(OP_ROL, 16'h5555, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b1), 1'b0, '0});
      alu_cases.push_back('{mk_req(OP_ROR, 16'h00FF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0), 1'b1,
                            mk_rsp(8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 16'h00FF, 8'h80)});
      alu_cases.push_back('{mk_req(OP_DEC_CMP, 16'h6666, 8'h00, 8'hFF, 8'h12, 1'b0, 1'b0), 1'b0,
                            '0});
      alu_cases.push_back('{mk_req(OP_DEC_CMP, 16'h7777, 8'h01, 8'h00, 8'h34, 1'b1, 1'b1), 1'b0,
                            '0});
      alu_cases.push_back('{mk_req(OP_INC_SUB, 16'h8888, 8'hFF, 8'h00, 8'h56, 1'b1, 1'b1), 1'b0,
                            '0});
      alu_cases.push_back('{mk_req(OP_INC_SUB, 16'h9999, 8'h7F, 8'h7F, 8'h78, 1'b0, 1'b0), 1'b0,
                            '0});
      alu_cases.push_back('{mk_req(OP_ROL_AND, 16'hAAAA, 8'h80, 8'hFF, 8'h9A, 1'b1, 1'b0), 1'b0,
                            '0});
      alu_cases.push_back('{mk_req(OP_ROR_ADD, 16'hBBBB, 8'h01, 8'hFF, 8'hBC, 1'b1, 1'b1), 1'b0,
                            '0});
      alu_cases.push_back('{mk_req(OP_ROR_ADD, 16'hCCCC, 8'hFE, 8'h7F, 8'hDE, 1'b0, 1'b0), 1'b0,
                            '0});
      alu_cases.push_back('{mk_req(OP_SHL_OR, 16'hDDDD, 8'hFF, 8'h00, 8'hF0, 1'b0, 1'b1), 1'b0,
                            '0});
      alu_cases.push_back('{mk_req(OP_SHR_EOR, 16'hEEEE, 8'hFF, 8'h7F, 8'h0F, 1'b1, 1'b0), 1'b0,
                            '0});
      alu_cases.push_back('{mk_req(OpSpareMin, 16'h5A5A, 8'hAB, 8'h00, 8'hFF, 1'b1, 1'b1), 1'b1,
                            mk_rsp(8'h00, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 16'h5A5A, 8'h00)});
      alu_cases.push_back('{mk_req(OpSpareMax, 16'hA5A5, 8'h00, 8'h80, 8'h00, 1'b0, 1'b0), 1'b1,
                            mk_rsp(8'h80, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'hA5A5, 8'h00)});
      alu_cases.push_back('{mk_req(OpSpareMin + 4'd1, 16'h0F0F, 8'hC3, 8'h3C, 8'h99, 1'b1, 1'b0),
                            1'b0, '0});

      // Reset is held from the start and released at a falling edge.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (alu_cases[i]) begin
         pace_sender();
         offer_item(alu_cases[i].stim,
                    alu_cases[i].typed ? alu_cases[i].want : alu_predict(alu_cases[i].stim));
      end

      // Random part. Halfway through, the sender stops until the pipeline
      // has drained completely, and then starts again from empty.
      for (int n = 0; n < RandomItems; n++) begin
         if (n == RandomItems / 2) drain_outcomes();
         pace_sender();
         it = random_item();
         offer_item(it, alu_predict(it));
      end

      drain_outcomes();
      repeat (SettleCycles) @(posedge clock);
      if (alu_outcomes_due.size() != 0)
         report_mismatch("results never delivered", alu_outcomes_due.size(), 0);
      if (mismatch_count == 0) begin
         $display("** cpu8_rmw_alu_with_flags: PASSED **");
      end else begin
         $display("** cpu8_rmw_alu_with_flags: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
